>>> src/urfd_pkg.sv
// Shared types and codes for the UART receive FIFO register device.
// Used by urfd_core and uart_rx_fifo_register_device.
package urfd_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 16;

	localparam logic [7:0] UPPER_LANES = 8'hF0;

	// operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_RECV  = 2'd2;

	// read map word indexes
	localparam logic [3:0] RD_DATA      = 4'd0;
	localparam logic [3:0] RD_CAN_WRITE = 4'd1;
	localparam logic [3:0] RD_CAN_READ  = 4'd2;
	localparam logic [3:0] RD_IRQ_EN    = 4'd3;
	localparam logic [3:0] RD_IRQ_LEVEL = 4'd4;
	localparam logic [3:0] RD_IRQ_ACT   = 4'd5;
	localparam logic [3:0] RD_ZERO      = 4'd6;

	// write map word indexes
	localparam logic [3:0] WR_TX        = 4'd0;
	localparam logic [3:0] WR_IRQ_EN    = 4'd1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [4:0]  byte_address;
		logic [7:0]  byte_enables;
		logic [63:0] write_data;
		logic [7:0]  received_byte;
	} req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        bus_error;
		logic        transmit_valid;
		logic [7:0]  transmit_byte;
		logic        rx_dropped;
		logic        interrupt_line;
	} rsp_t;

endpackage

>>> src/urfd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module urfd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> src/urfd_core.sv
// Register file, receive FIFO control and result logic of the UART device.
// Depends on urfd_pkg and urfd_ram.
module urfd_core #(
	parameter int unsigned FIFO_DEPTH = urfd_pkg::FIFO_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  urfd_pkg::req_t item,
	output urfd_pkg::rsp_t result
);

	import urfd_pkg::*;

	localparam int unsigned PW = $clog2(FIFO_DEPTH);
	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
	localparam logic [PW-1:0] LAST_C  = PW'(FIFO_DEPTH - 1);

	logic [PW-1:0] rp_q, rp_nxt;
	logic [PW-1:0] wp_q, wp_nxt;
	logic [CW-1:0] count_q, count_nxt;
	logic          all_written_q, all_written_nxt;
	logic [31:0]   irq_en_q, irq_en_nxt;
	logic          level_q, level_nxt;

	logic          ram_wr_en;
	logic [7:0]    ram_rd_data;
	logic          byp_hit_q;
	logic [7:0]    byp_data_q;

	logic          upper;
	logic [3:0]    idx;
	logic [31:0]   wvalue;
	logic          empty;
	logic          full;
	logic [7:0]    head_byte;
	logic [31:0]   rvalue;

	always_comb begin
		upper  = |(item.byte_enables & UPPER_LANES);
		idx    = {1'b0, item.byte_address[4:2]} + {3'b000, upper};
		wvalue = upper ? item.write_data[63:32] : item.write_data[31:0];
		empty  = (count_q == '0);
		full   = (count_q == DEPTH_C);
		// slot at the read pointer was never written while the FIFO has not wrapped
		if (empty && !all_written_q) begin
			head_byte = 8'h00;
		end else begin
			head_byte = byp_hit_q ? byp_data_q : ram_rd_data;
		end
	end

	always_comb begin
		rp_nxt          = rp_q;
		wp_nxt          = wp_q;
		count_nxt       = count_q;
		all_written_nxt = all_written_q;
		irq_en_nxt      = irq_en_q;
		level_nxt       = level_q;
		ram_wr_en       = 1'b0;
		rvalue          = 32'h0;
		result          = '0;

		case (item.operation)
			OP_WRITE: begin
				case (idx)
					WR_TX: begin
						result.transmit_valid = 1'b1;
						result.transmit_byte  = item.write_data[7:0];
					end
					WR_IRQ_EN: begin
						irq_en_nxt = wvalue;
					end
					default: begin
						result.bus_error = 1'b1;
					end
				endcase
			end
			OP_READ: begin
				case (idx)
					RD_DATA: begin
						rvalue = {24'h0, head_byte};
						if (!empty) begin
							count_nxt = count_q - 1'b1;
							rp_nxt    = (rp_q == LAST_C) ? '0 : rp_q + 1'b1;
							if (count_q == CW'(1)) begin
								level_nxt = 1'b0;
							end
						end
					end
					RD_CAN_WRITE: rvalue = 32'h1;
					RD_CAN_READ:  rvalue = {31'h0, !empty};
					RD_IRQ_EN:    rvalue = irq_en_q;
					RD_IRQ_LEVEL: rvalue = {31'h0, level_q};
					RD_IRQ_ACT:   rvalue = irq_en_q & {31'h0, level_q};
					RD_ZERO:      rvalue = 32'h0;
					default: begin
						result.bus_error = 1'b1;
					end
				endcase
				if (!result.bus_error) begin
					result.read_data = upper ? {rvalue, 32'h0} : {32'h0, rvalue};
				end
			end
			OP_RECV: begin
				if (full) begin
					result.rx_dropped = 1'b1;
				end else begin
					ram_wr_en = 1'b1;
					count_nxt = count_q + 1'b1;
					wp_nxt    = (wp_q == LAST_C) ? '0 : wp_q + 1'b1;
					level_nxt = 1'b1;
					if (wp_q == LAST_C) begin
						all_written_nxt = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// hold state unless the item moves on this cycle
		if (!go) begin
			rp_nxt          = rp_q;
			wp_nxt          = wp_q;
			count_nxt       = count_q;
			all_written_nxt = all_written_q;
			irq_en_nxt      = irq_en_q;
			level_nxt       = level_q;
			ram_wr_en       = 1'b0;
		end

		result.interrupt_line = level_nxt & irq_en_nxt[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q          <= '0;
			wp_q          <= '0;
			count_q       <= '0;
			all_written_q <= 1'b0;
			irq_en_q      <= 32'h0;
			level_q       <= 1'b0;
			byp_hit_q     <= 1'b0;
		end else begin
			rp_q          <= rp_nxt;
			wp_q          <= wp_nxt;
			count_q       <= count_nxt;
			all_written_q <= all_written_nxt;
			irq_en_q      <= irq_en_nxt;
			level_q       <= level_nxt;
			// forward a byte written to the slot being read in the same cycle
			byp_hit_q     <= ram_wr_en && (wp_q == rp_nxt);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= item.received_byte;
	end

	// read ahead at the pointer the next item will see
	urfd_ram #(
		.WIDTH (8),
		.DEPTH (FIFO_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (wp_q),
		.wr_data (item.received_byte),
		.rd_addr (rp_nxt),
		.rd_data (ram_rd_data)
	);

endmodule

>>> src/uart_rx_fifo_register_device.sv
// UART register device with receive FIFO and level interrupt: top level.
// Depends on urfd_pkg and urfd_core.
//
// Usage:
//   The req channel carries one word per bus write, bus read or byte received
//   from the host; the rsp channel returns exactly one word per req word, in
//   order, with read data, bus error, transmit byte, drop flag and interrupt
//   level. Both channels use valid/stall; a word moves when valid is high and
//   stall is low.
//   A request enters the input register when it is taken, and its result
//   enters the result register when that word moves on, which rsp_stall
//   can hold off. Throughput: one word per cycle while rsp_stall does not
//   hold a result; every word is a single register and FIFO update done
//   between those registers, with the FIFO store read ahead at the next
//   read pointer.
//   While rsp_stall holds a result, the input register still takes a word
//   if it is empty, then req_stall rises until the result is taken.
//   Reset (arst_n low) empties the FIFO, clears the interrupt enable and the
//   pending level. The byte store needs no clearing pass: until the write
//   pointer has wrapped once, a read of the empty FIFO returns zero.
module uart_rx_fifo_register_device #(
	parameter int unsigned FIFO_DEPTH = urfd_pkg::FIFO_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  urfd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output urfd_pkg::rsp_t rsp
);

	import urfd_pkg::*;

	logic valid_s1;
	req_t req_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t core_rsp;
	logic adv;
	logic go;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign go        = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (go) begin
			rsp_q <= core_rsp;
		end
	end

	urfd_core #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (req_s1),
		.result (core_rsp)
	);

endmodule
